[rtl/ffpr_pkg.sv]
// Package with shared types, codes and defaults for the fixed frame page replacement unit.
`timescale 1ns / 1ps
package ffpr_pkg;

  // Default sizes of the frame table.
  localparam int unsigned FramesDef    = 32;
  localparam int unsigned PageBitsDef  = 20;
  localparam int unsigned StampBitsDef = 32;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned PageW     = 20;
  localparam int unsigned FrameW    = 5;
  localparam int unsigned CountW    = 32;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 64;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 6;
  localparam int unsigned PolicyW   = 2;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CfgPolicy = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgFrames = 1'b1;

  // Replacement policy codes.
  localparam logic [PolicyW-1:0] PolFifo  = 2'd0;
  localparam logic [PolicyW-1:0] PolLru   = 2'd1;
  localparam logic [PolicyW-1:0] PolLfu   = 2'd2;
  localparam logic [PolicyW-1:0] PolClock = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DECIDE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic match;
    logic scan_init;
    logic scan_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic resolved;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

[rtl/ffpr_ctrl.sv]
// Controller state machine that sequences lookup, victim scan and commit.
`timescale 1ns / 1ps
module ffpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  ffpr_pkg::status_t status_i,
  output ffpr_pkg::cmd_t    cmd_o
);
  import ffpr_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_MATCH;
      end
      ST_MATCH:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = status_i.resolved ? ST_COMMIT : ST_SCAN;
      ST_SCAN: begin
        if (status_i.scan_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.start     = s_axis_tvalid_i;
      end
      ST_MATCH:  cmd_o.match = 1'b1;
      ST_DECIDE: cmd_o.scan_init = !status_i.resolved;
      ST_SCAN:   cmd_o.scan_step = 1'b1;
      ST_COMMIT: cmd_o.commit = status_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/ffpr_datapath.sv]
// Datapath with the frame table, lookup, victim scan, commit and result register.
`timescale 1ns / 1ps
module ffpr_datapath #(
  parameter int unsigned FRAMES     = ffpr_pkg::FramesDef,
  parameter int unsigned PAGE_BITS  = ffpr_pkg::PageBitsDef,
  parameter int unsigned STAMP_BITS = ffpr_pkg::StampBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ffpr_pkg::InDataW-1:0]       s_axis_tdata_i,
  input  logic                               cfg_we_i,
  input  logic [ffpr_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [ffpr_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  ffpr_pkg::cmd_t                     cmd_i,
  output ffpr_pkg::status_t                  status_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [ffpr_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import ffpr_pkg::*;

  localparam int unsigned IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CntW = $clog2(FRAMES + 1);
  localparam int unsigned CfgCmpW = (CntW > CfgDataW) ? CntW : CfgDataW;

  // Configuration.
  logic [PolicyW-1:0]  policy_q;
  logic [CfgDataW-1:0] frames_q;

  // Frame table.
  logic [PAGE_BITS-1:0]  page_q  [FRAMES];
  logic [STAMP_BITS-1:0] stamp_q [FRAMES];
  logic [CountW-1:0]     count_q [FRAMES];
  logic [FRAMES-1:0]     valid_q;
  logic [FRAMES-1:0]     ref_q;
  logic [IdxW-1:0]       hand_q;
  logic [STAMP_BITS-1:0] time_q;
  logic [CountW-1:0]     faults_q;

  // Request and search state.
  logic [PAGE_BITS-1:0]  req_q;
  logic [CntW-1:0]       n_q;
  logic                  hit_q;
  logic                  empty_q;
  logic [IdxW-1:0]       best_q;
  logic [STAMP_BITS-1:0] best_stamp_q;
  logic [CountW-1:0]     best_count_q;
  logic [CntW-1:0]       scan_q;

  // Result register.
  logic                  out_valid_q;
  logic [OutDataW-1:0]   out_data_q;

  // Effective frame count: zero acts as one, large values clip to the table size.
  logic [CntW-1:0] n_eff;
  always_comb begin
    if (frames_q == '0) begin
      n_eff = CntW'(1);
    end else if (CfgCmpW'(frames_q) > CfgCmpW'(FRAMES)) begin
      n_eff = CntW'(FRAMES);
    end else begin
      n_eff = CntW'(frames_q);
    end
  end

  // Parallel compare and lowest-index priority pick for hits and empty frames.
  logic            hit_any, empty_any;
  logic [IdxW-1:0] hit_idx, empty_idx;
  always_comb begin
    hit_any   = 1'b0;
    empty_any = 1'b0;
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (CntW'(i) < n_q) begin
        if (valid_q[i] && page_q[i] == req_q) begin
          hit_any = 1'b1;
          hit_idx = IdxW'(i);
        end
        if (!valid_q[i]) begin
          empty_any = 1'b1;
          empty_idx = IdxW'(i);
        end
      end
    end
  end

  // Scan helpers.
  logic [IdxW-1:0] scan_idx;
  logic [CntW-1:0] scan_next;
  logic [CntW-1:0] hand_start;
  logic            is_clock;
  logic            better;
  assign scan_idx  = scan_q[IdxW-1:0];
  assign scan_next = (scan_q + CntW'(1) >= n_q) ? '0 : scan_q + CntW'(1);
  assign hand_start = (CntW'(hand_q) >= n_q) ? '0 : CntW'(hand_q);
  assign is_clock  = (policy_q == PolClock);

  always_comb begin
    if (policy_q == PolLfu) begin
      better = (count_q[scan_idx] < best_count_q) ||
               (count_q[scan_idx] == best_count_q && stamp_q[scan_idx] < best_stamp_q);
    end else begin
      better = stamp_q[scan_idx] < best_stamp_q;
    end
  end

  // Status to the controller.
  assign status_o.resolved  = hit_q || empty_q;
  assign status_o.scan_done = is_clock ? !ref_q[scan_idx] : (scan_q >= n_q);
  assign status_o.out_free  = !out_valid_q || m_axis_tready_i;

  // Commit values.
  logic                  evict;
  logic [STAMP_BITS-1:0] time_inc;
  logic [CountW-1:0]     fault_next;
  assign evict      = !hit_q && !empty_q;
  assign time_inc   = (time_q == '1) ? time_q : time_q + STAMP_BITS'(1);
  assign fault_next = (faults_q == '1) ? faults_q : faults_q + CountW'(1);

  // Control registers with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= PolFifo;
      frames_q    <= CfgDataW'(32);
      valid_q     <= '0;
      ref_q       <= '1;
      hand_q      <= '0;
      time_q      <= '0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgPolicy: policy_q <= cfg_wdata_i[PolicyW-1:0];
          CfgFrames: frames_q <= cfg_wdata_i;
          default:   policy_q <= policy_q;
        endcase
      end
      // Clock sweep clears reference bits until it finds a clear one.
      if (cmd_i.scan_step && is_clock) begin
        if (ref_q[scan_idx]) begin
          ref_q[scan_idx] <= 1'b0;
        end else begin
          hand_q <= scan_next[IdxW-1:0];
        end
      end
      if (m_axis_tvalid_o && m_axis_tready_i) out_valid_q <= 1'b0;
      if (cmd_i.commit) begin
        ref_q[best_q] <= 1'b1;
        time_q        <= time_inc;
        out_valid_q   <= 1'b1;
        if (!hit_q) begin
          valid_q[best_q] <= 1'b1;
          faults_q        <= fault_next;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= PAGE_BITS'(s_axis_tdata_i[PageW-1:0]);
      n_q   <= n_eff;
    end
    if (cmd_i.match) begin
      hit_q   <= hit_any;
      empty_q <= empty_any;
      best_q  <= hit_any ? hit_idx : empty_idx;
    end
    // Start the victim search.
    if (cmd_i.scan_init) begin
      if (is_clock) begin
        scan_q <= hand_start;
      end else begin
        best_q       <= '0;
        best_stamp_q <= stamp_q[0];
        best_count_q <= count_q[0];
        scan_q       <= CntW'(1);
      end
    end
    // One frame per cycle.
    if (cmd_i.scan_step) begin
      if (is_clock) begin
        if (ref_q[scan_idx]) begin
          scan_q <= scan_next;
        end else begin
          best_q <= scan_idx;
        end
      end else if (scan_q < n_q) begin
        if (better) begin
          best_q       <= scan_idx;
          best_stamp_q <= stamp_q[scan_idx];
          best_count_q <= count_q[scan_idx];
        end
        scan_q <= scan_q + CntW'(1);
      end
    end
    // Update the chosen frame and load the result.
    if (cmd_i.commit) begin
      if (hit_q) begin
        if (count_q[best_q] != '1) count_q[best_q] <= count_q[best_q] + CountW'(1);
        if (policy_q != PolFifo) stamp_q[best_q] <= time_q;
      end else begin
        page_q[best_q]  <= req_q;
        stamp_q[best_q] <= time_q;
        count_q[best_q] <= CountW'(1);
      end
      out_data_q <= {
        5'b0,
        hit_q ? faults_q : fault_next,
        evict ? PageW'(page_q[best_q]) : PageW'(0),
        evict,
        FrameW'(best_q),
        !hit_q
      };
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

[rtl/fixed_frame_page_replacement.sv]
// Top level of the fixed frame page replacement unit.
`timescale 1ns / 1ps
// Takes one page reference per input transfer and returns one result transfer: hit or
// fault, the frame used, the page displaced (if any) and a saturating fault count.
// Policy register (index 0) selects FIFO, LRU, LFU or clock; register 1 sets how many
// frames, from frame zero, are searched. Write them only while the block is idle.
// A hit or a fill of an empty frame passes through accept, parallel compare, decide and
// commit. A replacement under FIFO, LRU or LFU adds a victim scan over the active frames,
// one frame per cycle through a single comparator. Under clock the hand sweeps one frame
// per cycle until it meets a clear reference bit. A finished result waits in an output
// register.
module fixed_frame_page_replacement #(
  parameter int unsigned FRAMES     = ffpr_pkg::FramesDef,
  parameter int unsigned PAGE_BITS  = ffpr_pkg::PageBitsDef,
  parameter int unsigned STAMP_BITS = ffpr_pkg::StampBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // page_number [19:0], zero fill [23:20]
  input  logic [ffpr_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // page_fault [0], frame_index [5:1], evicted_valid [6], evicted_page [26:7],
  // fault_total [58:27], zero fill [63:59]
  output logic [ffpr_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  input  logic                           cfg_we_i,
  input  logic [ffpr_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ffpr_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import ffpr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  ffpr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  // Frame table and result path.
  ffpr_datapath #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

[verif/ffpr_checker.sv]
// Checker that predicts and compares page replacement results on the stream ports.
`timescale 1ns / 1ps
module ffpr_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // page_number [19:0], zero fill [23:20]
  input  logic [ffpr_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  // page_fault [0], frame_index [5:1], evicted_valid [6], evicted_page [26:7],
  // fault_total [58:27], zero fill [63:59]
  input  logic [ffpr_pkg::OutDataW-1:0]  m_axis_tdata_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic                           cfg_we_i,
  input  logic [ffpr_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ffpr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output int                             error_count_o,
  output int                             pending_o
);
  import ffpr_pkg::*;

  localparam int Frames = 32;

  typedef struct packed {
    logic              fault;
    logic [FrameW-1:0] frame;
    logic              ev_valid;
    logic [PageW-1:0]  ev_page;
    logic [CountW-1:0] total;
  } outcome_t;

  // Shadow copy of the frame table and registers.
  logic [PolicyW-1:0]  policy_q;
  logic [CfgDataW-1:0] frames_q;
  logic [PageW-1:0]    page_q   [Frames];
  bit                  valid_q  [Frames];
  logic [31:0]         stamp_q  [Frames];
  logic [31:0]         uses_q   [Frames];
  bit                  refbit_q [Frames];
  int                  hand_q;
  logic [31:0]         now_q;
  logic [31:0]         faults_q;

  outcome_t pending_results[$];
  int       errors;

  assign error_count_o = errors;
  assign pending_o     = pending_results.size();

  // Works out the outcome of one page reference and updates the shadow table.
  task automatic resolve_reference(input logic [PageW-1:0] page);
    int       n, idx, best, h;
    bit       hit, empty;
    outcome_t res;
    n   = (frames_q == 0) ? 1 : (frames_q > Frames) ? Frames : int'(frames_q);
    hit = 0;
    idx = 0;
    res = '0;
    for (int i = 0; i < n; i++) begin
      if (!hit && valid_q[i] && page_q[i] == page) begin
        hit = 1;
        idx = i;
      end
    end
    if (hit) begin
      refbit_q[idx] = 1;
      if (uses_q[idx] != 32'hFFFF_FFFF) uses_q[idx]++;
      if (policy_q != PolFifo) stamp_q[idx] = now_q;
    end else begin
      empty = 0;
      for (int i = 0; i < n; i++) begin
        if (!empty && !valid_q[i]) begin
          empty = 1;
          idx = i;
        end
      end
      if (!empty) begin
        best = 0;
        if (policy_q == PolClock) begin
          // Second chance sweep: clear set reference bits until one is found clear.
          h = (hand_q >= n) ? 0 : hand_q;
          while (refbit_q[h]) begin
            refbit_q[h] = 0;
            h = (h + 1 >= n) ? 0 : h + 1;
          end
          hand_q = (h + 1 >= n) ? 0 : h + 1;
          best = h;
        end else if (policy_q == PolLfu) begin
          for (int i = 1; i < n; i++) begin
            if (uses_q[i] < uses_q[best] ||
                (uses_q[i] == uses_q[best] && stamp_q[i] < stamp_q[best])) best = i;
          end
        end else begin
          for (int i = 1; i < n; i++) begin
            if (stamp_q[i] < stamp_q[best]) best = i;
          end
        end
        idx          = best;
        res.ev_valid = 1;
        res.ev_page  = page_q[idx];
      end
      page_q[idx]   = page;
      valid_q[idx]  = 1;
      stamp_q[idx]  = now_q;
      uses_q[idx]   = 1;
      refbit_q[idx] = 1;
      if (faults_q != 32'hFFFF_FFFF) faults_q++;
    end
    if (now_q != 32'hFFFF_FFFF) now_q++;
    res.fault = !hit;
    res.frame = idx[FrameW-1:0];
    res.total = faults_q;
    pending_results.push_back(res);
  endtask

  // Compares one result transfer with the oldest expectation.
  task automatic compare_result(input logic [OutDataW-1:0] data);
    outcome_t want, got;
    got.fault    = data[0];
    got.frame    = data[5:1];
    got.ev_valid = data[6];
    got.ev_page  = data[26:7];
    got.total    = data[58:27];
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $realtime, data);
    end else begin
      want = pending_results.pop_front();
      if (got.fault !== want.fault) begin
        errors++;
        $display("%0t: page_fault expected %0d actual %0d", $realtime, want.fault, got.fault);
      end
      if (got.frame !== want.frame) begin
        errors++;
        $display("%0t: frame_index expected %0d actual %0d", $realtime, want.frame, got.frame);
      end
      if (got.ev_valid !== want.ev_valid) begin
        errors++;
        $display("%0t: evicted_valid expected %0d actual %0d", $realtime, want.ev_valid,
                 got.ev_valid);
      end
      if (got.ev_page !== want.ev_page) begin
        errors++;
        $display("%0t: evicted_page expected %h actual %h", $realtime, want.ev_page,
                 got.ev_page);
      end
      if (got.total !== want.total) begin
        errors++;
        $display("%0t: fault_total expected %0d actual %0d", $realtime, want.total, got.total);
      end
    end
  endtask

  // Watch register writes and transfers on both channels.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q = PolFifo;
      frames_q = 6'd32;
      for (int i = 0; i < Frames; i++) begin
        valid_q[i]  = 0;
        refbit_q[i] = 1;
      end
      hand_q   = 0;
      now_q    = '0;
      faults_q = '0;
      pending_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgPolicy) policy_q = cfg_wdata_i[PolicyW-1:0];
        else if (cfg_index_i == CfgFrames) frames_q = cfg_wdata_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) resolve_reference(s_axis_tdata_i[PageW-1:0]);
      if (m_axis_tvalid_i && m_axis_tready_i) compare_result(m_axis_tdata_i);
    end
  end

  initial errors = 0;

endmodule

[verif/tb.sv]
// Testbench top that drives page references and registers and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import ffpr_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic [InDataW-1:0]   s_axis_tdata_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [OutDataW-1:0]  m_axis_tdata_o;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  int                   error_count;
  int                   pending;

  bit calm;
  bit hold_req;
  int active_n;
  logic [PageW-1:0] page_base;

  fixed_frame_page_replacement uut (.*);

  ffpr_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tdata_i, .s_axis_tvalid_i,
    .s_axis_tready_i(s_axis_tready_o), .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .cfg_we_i, .cfg_index_i,
    .cfg_wdata_i, .error_count_o(error_count), .pending_o(pending)
  );

  // 4 ns clock.
  initial clk_i = 0;
  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // Hard stop if the run hangs.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    m_axis_tready_i = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 0;
        repeat (150) @(posedge clk_i);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1;
    end
  end

  // One reference transfer, with an occasional idle burst ahead of it.
  task automatic send_page(input logic [PageW-1:0] page);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i  <= {{(InDataW - PageW){1'b0}}, page};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Register write, issued once the block has drained.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    s_axis_tvalid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == CfgFrames) active_n = (val == 0) ? 1 : (val > 32) ? 32 : int'(val);
  endtask

  // Page drawn mostly from a small set around a base so that hits happen.
  function automatic logic [PageW-1:0] pick_page();
    if ($urandom_range(0, 9) == 0) return PageW'($urandom);
    return page_base ^ PageW'($urandom_range(0, active_n + active_n / 2 + 1));
  endfunction

  initial begin
    logic [CfgDataW-1:0] frame_settings [12];
    rst_ni          = 0;
    s_axis_tvalid_i = 0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 0;
    cfg_index_i     = CfgPolicy;
    cfg_wdata_i     = '0;
    calm            = 0;
    hold_req        = 0;
    active_n        = 32;
    frame_settings  = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd4, 6'd8, 6'd16, 6'd3,
                        6'd33, 6'd5, 6'd2, 6'd12};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: extreme pages, FIFO eviction, duplicate copies, frame count limits.
    write_reg(CfgFrames, 6'd2);
    send_page('0);
    send_page('1);
    send_page('0);
    send_page(20'd5);
    send_page('1);
    send_page('0);
    write_reg(CfgFrames, 6'd1);
    send_page('0);
    write_reg(CfgFrames, 6'd2);
    send_page('0);
    send_page(20'hAAAAA);
    write_reg(CfgFrames, 6'd0);
    send_page(20'd7);
    send_page(20'h55555);
    write_reg(CfgPolicy, PolClock);
    write_reg(CfgFrames, 6'd40);
    for (int i = 0; i < 6; i++) send_page(PageW'(i * 3));

    // Random phases across every policy and frame count setting.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CfgPolicy, PolicyW'(ph % 4));
      write_reg(CfgFrames, frame_settings[ph]);
      page_base = PageW'($urandom);
      calm = (ph >= 10);
      if (ph == 2) hold_req = 1;
      for (int k = 0; k < 32; k++) send_page(pick_page());
    end
    s_axis_tvalid_i <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
